@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// No dependencies; included by the checker by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define AHCT_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ahct assertion failed");

// Clocked assertion that is also checked during reset.
`define AHCT_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ahct assertion failed");

`endif

@@ src/ahct_pkg.sv @@
// Shared types and constants of the ARP host conflict table.
// No dependencies; used by the interfaces and every module of the block.
package ahct_pkg;

  localparam int ET_W       = 16;
  localparam int MAC_W      = 48;
  localparam int IP_W       = 32;
  localparam int OCT_W      = 8;
  localparam int PFX_W      = IP_W - OCT_W;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  localparam logic [ET_W-1:0] ETHERTYPE_ARP = 16'h0806;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SUBNET_PREFIX = 2'd0,
    REG_OWN_IP        = 2'd1,
    REG_OWN_MAC       = 2'd2
  } cfg_reg_t;

  // Write strobes from the sequencer to the table memories.
  typedef struct packed {
    logic cnt_we;
    logic st_we;
  } mem_ctl_t;

  // One report as it leaves the sequencer.
  typedef struct packed {
    logic [OCT_W-1:0] host_octet;
    logic [MAC_W-1:0] host_mac;
    logic             conflict;
    logic             is_self;
    logic             stored;
  } report_t;

endpackage

@@ src/ahct_if.sv @@
// Valid/ready channel interfaces for received frames and for reports.
// Depends on ahct_pkg for the field widths.
interface ahct_frame_if;
  import ahct_pkg::*;

  logic             valid;
  logic             ready;
  logic [ET_W-1:0]  ether_type;
  logic [MAC_W-1:0] sender_mac;
  logic [IP_W-1:0]  sender_ip;

  modport source (output valid, ether_type, sender_mac, sender_ip, input ready);
  modport sink (input valid, ether_type, sender_mac, sender_ip, output ready);
endinterface

interface ahct_report_if;
  import ahct_pkg::*;

  logic             valid;
  logic             ready;
  logic [OCT_W-1:0] host_octet;
  logic [MAC_W-1:0] host_mac;
  logic             conflict;
  logic             is_self;
  logic             stored;

  modport source (output valid, host_octet, host_mac, conflict, is_self, stored,
                  input ready);
  modport sink (input valid, host_octet, host_mac, conflict, is_self, stored,
                output ready);
endinterface

@@ src/arp_host_conflict_table.sv @@
// Top level of the ARP host conflict table: configuration registers,
// report register, and the sequencer and table memories (ahct_pkg, ahct_if).
//
//   channel  | dir | transaction
//   frame    | in  | ether_type, sender_mac, sender_ip
//   report   | out | host_octet, host_mac, conflict, is_self, stored
//   cfg      | in  | cfg_we, cfg_index, cfg_data (write only)
//
// A filtered-out frame is dropped while the sequencer stays idle; a first
// sighting goes from lookup to report. A known host is scanned: its stored MACs
// are compared one per cycle by the shared 48-bit comparator against the single-port
// MAC store; a MAC found in the store ends the scan with no report.
// Reset is synchronous; the host counts are cleared at once by valid bits.
// A stalled report holds in the report register; a new frame is taken
// meanwhile and the sequencer waits only when it has a report of its own.
module arp_host_conflict_table #(
  parameter int HOST_ENTRIES  = 256,
  parameter int MACS_PER_HOST = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [ahct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ahct_pkg::CFG_DATA_W-1:0]     cfg_data,
  ahct_frame_if.sink                          frame,
  ahct_report_if.source                       report
);
  import ahct_pkg::*;

  localparam int HW = $clog2(HOST_ENTRIES);
  localparam int AW = $clog2(HOST_ENTRIES * MACS_PER_HOST);

  logic [PFX_W-1:0] subnet_prefix;
  logic [IP_W-1:0]  own_ip;
  logic [MAC_W-1:0] own_mac;

  mem_ctl_t         ctl;
  logic [HW-1:0]    host;
  logic [CNT_W-1:0] cnt_wdata;
  logic [CNT_W-1:0] cnt_rdata;
  logic [AW-1:0]    st_addr;
  logic [MAC_W-1:0] st_wdata;
  logic [MAC_W-1:0] st_rdata;
  report_t          rpt;
  logic             rpt_valid;
  logic             rpt_take;

  report_t          out_q;
  logic             out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      subnet_prefix <= '0;
      own_ip        <= '0;
      own_mac       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SUBNET_PREFIX: subnet_prefix <= cfg_data[PFX_W-1:0];
        REG_OWN_IP:        own_ip        <= cfg_data[IP_W-1:0];
        REG_OWN_MAC:       own_mac       <= cfg_data[MAC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ahct_seq #(
    .HOST_ENTRIES  (HOST_ENTRIES),
    .MACS_PER_HOST (MACS_PER_HOST)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .frame         (frame),
    .subnet_prefix (subnet_prefix),
    .own_ip        (own_ip),
    .own_mac       (own_mac),
    .ctl           (ctl),
    .host          (host),
    .cnt_wdata     (cnt_wdata),
    .cnt_rdata     (cnt_rdata),
    .st_addr       (st_addr),
    .st_wdata      (st_wdata),
    .st_rdata      (st_rdata),
    .rpt           (rpt),
    .rpt_valid     (rpt_valid),
    .rpt_take      (rpt_take)
  );

  ahct_mem #(
    .HOST_ENTRIES  (HOST_ENTRIES),
    .MACS_PER_HOST (MACS_PER_HOST)
  ) u_mem (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .host      (host),
    .cnt_wdata (cnt_wdata),
    .cnt_rdata (cnt_rdata),
    .st_addr   (st_addr),
    .st_wdata  (st_wdata),
    .st_rdata  (st_rdata)
  );

  // Report register between the sequencer and the output channel.
  assign rpt_take = rpt_valid && (!out_valid || report.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rpt_take) begin
      out_valid <= 1'b1;
      out_q     <= rpt;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign report.valid      = out_valid;
  assign report.host_octet = out_q.host_octet;
  assign report.host_mac   = out_q.host_mac;
  assign report.conflict   = out_q.conflict;
  assign report.is_self    = out_q.is_self;
  assign report.stored     = out_q.stored;

endmodule

@@ src/ahct_mem.sv @@
// Host table storage: the MAC store and the per-host MAC counts.
// Depends on ahct_pkg; driven by ahct_seq.
module ahct_mem #(
  parameter int HOST_ENTRIES  = 256,
  parameter int MACS_PER_HOST = 8,
  localparam int HW = $clog2(HOST_ENTRIES),
  localparam int AW = $clog2(HOST_ENTRIES * MACS_PER_HOST)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ahct_pkg::mem_ctl_t                 ctl,
  input  logic [HW-1:0]                      host,
  input  logic [ahct_pkg::CNT_W-1:0]         cnt_wdata,
  output logic [ahct_pkg::CNT_W-1:0]         cnt_rdata,
  input  logic [AW-1:0]                      st_addr,
  input  logic [ahct_pkg::MAC_W-1:0]         st_wdata,
  output logic [ahct_pkg::MAC_W-1:0]         st_rdata
);
  import ahct_pkg::*;

  logic [MAC_W-1:0]        store_mem [HOST_ENTRIES * MACS_PER_HOST];
  logic [CNT_W-1:0]        count_mem [HOST_ENTRIES];
  logic [HOST_ENTRIES-1:0] cnt_valid;
  logic [CNT_W-1:0]        cnt_q;
  logic                    cnt_valid_q;

  // MAC store: single port, a write takes the port for that cycle.
  always_ff @(posedge clk) begin
    if (ctl.st_we) begin
      store_mem[st_addr] <= st_wdata;
    end else begin
      st_rdata <= store_mem[st_addr];
    end
  end

  // Count memory with a registered read.
  always_ff @(posedge clk) begin
    if (ctl.cnt_we) begin
      count_mem[host] <= cnt_wdata;
    end else begin
      cnt_q <= count_mem[host];
    end
  end

  // One valid bit per host stands in for clearing the counts at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid   <= '0;
      cnt_valid_q <= 1'b0;
    end else begin
      if (ctl.cnt_we) begin
        cnt_valid[host] <= 1'b1;
      end
      cnt_valid_q <= cnt_valid[host];
    end
  end

  // A host that was never written reads as a count of zero.
  assign cnt_rdata = cnt_valid_q ? cnt_q : '0;

endmodule

@@ src/ahct_seq.sv @@
// Sequencer of the host table: frame filter, MAC scan with one shared
// 48-bit comparator, table update and report build. Depends on ahct_pkg.
module ahct_seq #(
  parameter int HOST_ENTRIES  = 256,
  parameter int MACS_PER_HOST = 8,
  localparam int HW = $clog2(HOST_ENTRIES),
  localparam int AW = $clog2(HOST_ENTRIES * MACS_PER_HOST)
) (
  input  logic                       clk,
  input  logic                       rst,
  ahct_frame_if.sink                 frame,
  input  logic [ahct_pkg::PFX_W-1:0] subnet_prefix,
  input  logic [ahct_pkg::IP_W-1:0]  own_ip,
  input  logic [ahct_pkg::MAC_W-1:0] own_mac,
  output ahct_pkg::mem_ctl_t         ctl,
  output logic [HW-1:0]              host,
  output logic [ahct_pkg::CNT_W-1:0] cnt_wdata,
  input  logic [ahct_pkg::CNT_W-1:0] cnt_rdata,
  output logic [AW-1:0]              st_addr,
  output logic [ahct_pkg::MAC_W-1:0] st_wdata,
  input  logic [ahct_pkg::MAC_W-1:0] st_rdata,
  output ahct_pkg::report_t          rpt,
  output logic                       rpt_valid,
  input  logic                       rpt_take
);
  import ahct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_REPORT
  } state_t;

  state_t           state;
  logic [MAC_W-1:0] mac_q;
  logic [OCT_W-1:0] octet_q;
  logic             self_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] k;

  logic [OCT_W-1:0] in_octet;
  logic             pass;
  logic [AW-1:0]    base;
  logic             match;
  logic             last;
  logic             room;

  // Frame filter: ARP only, inside the subnet, and inside the table.
  assign in_octet = frame.sender_ip[OCT_W-1:0];
  assign pass = (frame.ether_type == ETHERTYPE_ARP) &&
                (frame.sender_ip[IP_W-1:OCT_W] == subnet_prefix) &&
                ({1'b0, in_octet} < (OCT_W + 1)'(HOST_ENTRIES));

  // Scan bookkeeping around the shared comparator.
  assign base  = AW'(AW'(octet_q[HW-1:0]) * AW'(MACS_PER_HOST));
  assign match = (st_rdata == mac_q);
  assign last  = (CNT_W'(k + CNT_W'(1)) == cnt_q);
  assign room  = (cnt_q < CNT_W'(MACS_PER_HOST));

  assign frame.ready = (state == S_IDLE);
  assign rpt_valid   = (state == S_REPORT);
  assign host        = (state == S_IDLE) ? in_octet[HW-1:0] : octet_q[HW-1:0];
  assign st_wdata    = mac_q;

  // Memory addresses and write strobes.
  always_comb begin
    ctl       = '0;
    st_addr   = base;
    cnt_wdata = CNT_W'(1);
    case (state)
      S_LOOKUP: begin
        if (cnt_rdata == '0) begin
          ctl.st_we  = 1'b1;
          ctl.cnt_we = 1'b1;
        end
      end
      S_SCAN: begin
        if (!match && last && room) begin
          ctl.st_we  = 1'b1;
          ctl.cnt_we = 1'b1;
          st_addr    = base + AW'(cnt_q);
          cnt_wdata  = cnt_q + CNT_W'(1);
        end else begin
          st_addr = base + AW'(k) + AW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // State and registered report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (frame.valid) begin
            mac_q   <= frame.sender_mac;
            octet_q <= in_octet;
            self_q  <= (frame.sender_ip == own_ip) && (frame.sender_mac == own_mac);
            if (pass) begin
              state <= S_LOOKUP;
            end
          end
        end
        S_LOOKUP: begin
          if (cnt_rdata == '0) begin
            rpt   <= '{host_octet: octet_q, host_mac: mac_q, conflict: 1'b0,
                       is_self: self_q, stored: 1'b1};
            state <= S_REPORT;
          end else begin
            k     <= '0;
            cnt_q <= cnt_rdata;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            state <= S_IDLE;
          end else if (last) begin
            rpt   <= '{host_octet: octet_q, host_mac: mac_q, conflict: 1'b1,
                       is_self: 1'b0, stored: room};
            state <= S_REPORT;
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        S_REPORT: begin
          if (rpt_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/ahct_checker.sv @@
// Port-level checker of the ARP host conflict table and its bind.
// Depends on ahct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ahct_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            frame_valid,
  input logic                            frame_ready,
  input logic [ahct_pkg::ET_W-1:0]       frame_ether_type,
  input logic                            report_valid,
  input logic                            report_ready,
  input logic [ahct_pkg::MAC_W-1:0]      report_host_mac,
  input logic                            report_conflict,
  input logic                            report_is_self,
  input logic                            report_stored
);
  import ahct_pkg::*;

  logic rpt_stall;
  logic drop_take;

  // A report offered but not taken, and a non-ARP frame being taken.
  assign rpt_stall = report_valid && !report_ready;
  assign drop_take = frame_valid && frame_ready && (frame_ether_type != ETHERTYPE_ARP);

  // A stalled report keeps its MAC.
  `AHCT_ASSERT(a_report_hold, clk, rst, rpt_stall |=> report_valid && $stable(report_host_mac))

  // Only a new host can be marked as this station.
  `AHCT_ASSERT(a_self_only_new, clk, rst, report_valid && report_conflict |-> !report_is_self)

  // A new host is always written into the table.
  `AHCT_ASSERT(a_new_stored, clk, rst, report_valid && !report_conflict |-> report_stored)

  // A frame that is not ARP is dropped at once and the block is ready again.
  `AHCT_ASSERT(a_drop_non_arp, clk, rst, drop_take |=> frame_ready)

  // No report is offered right after reset.
  `AHCT_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !report_valid)

endmodule

bind arp_host_conflict_table ahct_checker u_ahct_checker (
  .clk              (clk),
  .rst              (rst),
  .frame_valid      (frame.valid),
  .frame_ready      (frame.ready),
  .frame_ether_type (frame.ether_type),
  .report_valid     (report.valid),
  .report_ready     (report.ready),
  .report_host_mac  (report.host_mac),
  .report_conflict  (report.conflict),
  .report_is_self   (report.is_self),
  .report_stored    (report.stored)
);

@@ tb/sv/arp_host_conflict_table_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ARP host conflict table. It drives frames and
// config writes, predicts every report and checks them. Needs ahct_pkg, ahct_if.
module arp_host_conflict_table_tb;
  import ahct_pkg::*;

  localparam int TBL_HOSTS      = 256;
  localparam int TBL_MACS       = 8;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 24;
  localparam int IDLE_LIMIT     = 4000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int NUM_PHASES     = 5;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int POOL_SIZE      = 12;
  localparam int WIN_SPAN       = 40;
  localparam int MAX_SHOWN      = 10;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum bit {ROW_PREDICTED, ROW_TYPED} row_kind_t;

  typedef struct {
    logic [ET_W-1:0]  et;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    row_kind_t        kind;
    bit               has_report;
    report_t          rep;
  } frame_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ahct_frame_if  frame_ch();
  ahct_report_if report_ch();

  arp_host_conflict_table #(
    .HOST_ENTRIES (TBL_HOSTS),
    .MACS_PER_HOST(TBL_MACS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .frame    (frame_ch),
    .report   (report_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the host table and the configuration registers.
  logic [PFX_W-1:0] tbl_prefix  = '0;
  logic [IP_W-1:0]  tbl_own_ip  = '0;
  logic [MAC_W-1:0] tbl_own_mac = '0;
  logic [MAC_W-1:0] host_macs [TBL_HOSTS][TBL_MACS];
  int               host_fill [TBL_HOSTS];

  report_t    pending_reports[$];
  frame_row_t directed_rows[$];

  int  error_count  = 0;
  int  reports_ok   = 0;
  int  frames_in    = 0;
  int  cfg_writes   = 0;
  int  new_hosts    = 0;
  int  self_marks   = 0;
  int  conflicts    = 0;
  int  full_reports = 0;
  int  burst_left   = 0;
  bit  squeeze_req  = 1'b0;
  bit  squeeze_done = 1'b0;

  function automatic report_t make_report(input logic [OCT_W-1:0] oct,
                                          input logic [MAC_W-1:0] mac,
                                          input logic c, input logic s,
                                          input logic st);
    report_t r;
    r.host_octet = oct;
    r.host_mac   = mac;
    r.conflict   = c;
    r.is_self    = s;
    r.stored     = st;
    return r;
  endfunction

  function automatic string fmt_report(input report_t r);
    return $sformatf("octet %0d mac %h conflict %0b self %0b stored %0b",
                     r.host_octet, r.host_mac, r.conflict, r.is_self, r.stored);
  endfunction

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [31:0] hi;
    logic [31:0] lo;
    hi = $urandom;
    lo = $urandom;
    return {hi[15:0], lo};
  endfunction

  // Works out the report for one frame and updates the host table shadow.
  function automatic bit host_table_update(input logic [ET_W-1:0] et,
                                           input logic [MAC_W-1:0] mac,
                                           input logic [IP_W-1:0] ip,
                                           output report_t rep);
    logic [OCT_W-1:0] oct;
    int fill;
    int k;
    oct = ip[OCT_W-1:0];
    rep = make_report(oct, mac, 1'b0, 1'b0, 1'b0);
    if (et != ETHERTYPE_ARP || ip[IP_W-1:OCT_W] != tbl_prefix) return 1'b0;
    if (int'(oct) >= TBL_HOSTS) return 1'b0;
    fill = host_fill[oct];
    // First sighting: store and report a new host.
    if (fill == 0) begin
      host_macs[oct][0] = mac;
      host_fill[oct]    = 1;
      rep.is_self = (ip == tbl_own_ip) && (mac == tbl_own_mac);
      rep.stored  = 1'b1;
      return 1'b1;
    end
    for (k = 0; k < fill; k++) begin
      if (host_macs[oct][k] == mac) return 1'b0;
    end
    // Unknown MAC for a known host: a conflict, stored while there is room.
    rep.conflict = 1'b1;
    if (fill < TBL_MACS) begin
      host_macs[oct][fill] = mac;
      host_fill[oct]       = fill + 1;
      rep.stored = 1'b1;
    end
    return 1'b1;
  endfunction

  // Sender idle gaps: mostly short, a few long, with bursts of back-to-back frames.
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = 30;
      return 0;
    end
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(input logic [ET_W-1:0] et, input logic [MAC_W-1:0] mac,
                         input logic [IP_W-1:0] ip, input row_kind_t kind,
                         input bit has_report, input report_t rep);
    frame_row_t row;
    row.et = et;
    row.mac = mac;
    row.ip = ip;
    row.kind = kind;
    row.has_report = has_report;
    row.rep = rep;
    directed_rows.push_back(row);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SUBNET_PREFIX: tbl_prefix  = data[PFX_W-1:0];
      REG_OWN_IP:        tbl_own_ip  = data[IP_W-1:0];
      REG_OWN_MAC:       tbl_own_mac = data[MAC_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Offers one frame, waits for the transaction, then records what it should cause.
  task automatic offer_frame(input logic [ET_W-1:0] et, input logic [MAC_W-1:0] mac,
                             input logic [IP_W-1:0] ip, input int gap,
                             input row_kind_t kind, input bit typed_has,
                             input report_t typed_rep);
    report_t rep;
    bit      has;
    frame_ch.valid      <= 1'b1;
    frame_ch.ether_type <= et;
    frame_ch.sender_mac <= mac;
    frame_ch.sender_ip  <= ip;
    do @(posedge clk); while (!(frame_ch.valid && frame_ch.ready));
    frames_in++;
    has = host_table_update(et, mac, ip, rep);
    if (kind == ROW_TYPED) begin
      has = typed_has;
      rep = typed_rep;
    end
    if (has) begin
      pending_reports.push_back(rep);
      if (rep.conflict) begin
        conflicts++;
        if (!rep.stored) full_reports++;
      end else begin
        new_hosts++;
        if (rep.is_self) self_marks++;
      end
    end
    if (gap > 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until all reports are in and the block has finished any silent frame.
  task automatic wait_idle();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    if (pending_reports.size() == 0) begin
      error_count++;
      if (error_count <= MAX_SHOWN)
        $display("ERROR: unexpected report: %s", fmt_report(got));
    end else begin
      want = pending_reports.pop_front();
      if (got.host_octet !== want.host_octet || got.host_mac !== want.host_mac ||
          got.conflict !== want.conflict || got.is_self !== want.is_self ||
          got.stored !== want.stored) begin
        error_count++;
        if (error_count <= MAX_SHOWN) begin
          $display("ERROR: report mismatch at %0t", $realtime);
          $display("  expected %s", fmt_report(want));
          $display("  actual   %s", fmt_report(got));
        end
      end else begin
        reports_ok++;
      end
    end
  endtask

  // Report monitor: every accepted transaction is checked against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && report_ch.valid && report_ch.ready)
      check_report(make_report(report_ch.host_octet, report_ch.host_mac,
                               report_ch.conflict, report_ch.is_self,
                               report_ch.stored));
  end

  // Report sink: random back-pressure, plus one long hold-off to fill the block.
  initial begin : report_sink
    int pick;
    int run;
    report_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        report_ch.ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          report_ch.ready <= 1'b1;
          run = $urandom_range(1, 20);
        end else if (pick < 95) begin
          report_ch.ready <= 1'b0;
          run = $urandom_range(1, 3);
        end else begin
          report_ch.ready <= 1'b0;
          run = $urandom_range(20, 60);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (frame_ch.valid && frame_ch.ready) ||
          (report_ch.valid && report_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus: directed rows under reset settings, then random phases.
  initial begin : stimulus
    int               pick;
    int               sel;
    int               win_base;
    int               relevant;
    int               relevant_total;
    logic [ET_W-1:0]  et;
    logic [MAC_W-1:0] mac;
    logic [IP_W-1:0]  ip;
    logic [OCT_W-1:0] oct;
    logic [31:0]      rnd_a;
    logic [31:0]      rnd_b;
    logic [PFX_W-1:0] prefix_cur;
    logic [IP_W-1:0]  own_ip_cur;
    logic [MAC_W-1:0] own_mac_cur;
    logic [MAC_W-1:0] mac_pool [POOL_SIZE];

    relevant_total = 0;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    frame_ch.valid      <= 1'b0;
    frame_ch.ether_type <= '0;
    frame_ch.sender_mac <= '0;
    frame_ch.sender_ip  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Registers are all zero after reset, so the own address is 0.0.0.0 / 0.
    add_row(16'h0000, '0, '0, ROW_TYPED, 1'b0, '0);
    add_row(16'hFFFF, '1, '1, ROW_TYPED, 1'b0, '0);
    add_row(ETHERTYPE_ARP + 16'd1, '0, '0, ROW_TYPED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, '0, '0, ROW_TYPED, 1'b1,
            make_report(8'h00, '0, 1'b0, 1'b1, 1'b1));
    add_row(ETHERTYPE_ARP, '0, 32'h0000_0100, ROW_TYPED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h1, 32'hFFFF_FF00, ROW_TYPED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, '1, 32'h0000_00FF, ROW_TYPED, 1'b1,
            make_report(8'hFF, '1, 1'b0, 1'b0, 1'b1));
    // Same host again, then enough new MACs to fill its entry and one more.
    add_row(ETHERTYPE_ARP, '1, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h0000_0000_0001, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h8000_0000_0000, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h5555_5555_5555, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'hAAAA_AAAA_AAAA, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h0123_4567_89AB, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'hFEDC_BA98_7654, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'hFFFF_FFFF_FFFE, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h7FFF_FFFF_FFFF, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, '1, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'hFFFF_FFFF_FFFE, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h7FFF_FFFF_FFFF, 32'h0000_00FF, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, 48'h1, 32'h0000_0000, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, '0, 32'h0000_0000, ROW_PREDICTED, 1'b0, '0);
    add_row(ETHERTYPE_ARP, '0, 32'h0000_0001, ROW_PREDICTED, 1'b0, '0);

    foreach (directed_rows[i])
      offer_frame(directed_rows[i].et, directed_rows[i].mac, directed_rows[i].ip,
                  next_gap(), directed_rows[i].kind, directed_rows[i].has_report,
                  directed_rows[i].rep);
    frame_ch.valid <= 1'b0;
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Pick a setting per phase; the extremes fall on fixed phases.
      win_base = p * 50;
      rnd_a = $urandom;
      prefix_cur  = rnd_a[PFX_W-1:0];
      own_mac_cur = rand_mac();
      oct = 8'(win_base + $urandom_range(0, WIN_SPAN - 1));
      case (p)
        1: begin
          prefix_cur  = '1;
          own_mac_cur = '1;
        end
        3: begin
          prefix_cur  = '0;
          own_mac_cur = '0;
        end
        default: ;
      endcase
      own_ip_cur = {prefix_cur, oct};
      if (p == 2) own_ip_cur = {~prefix_cur, oct};
      if (p == 4) own_ip_cur = '1;

      // Upper data bits are random to exercise the width masking.
      rnd_a = $urandom;
      rnd_b = $urandom;
      write_reg(REG_SUBNET_PREFIX, {rnd_a[23:0], prefix_cur});
      write_reg(REG_OWN_IP, {rnd_b[15:0], own_ip_cur});
      write_reg(REG_OWN_MAC, own_mac_cur);
      write_reg(REG_SPARE, rand_mac());
      cfg_we <= 1'b0;

      foreach (mac_pool[i]) mac_pool[i] = rand_mac();
      if (p == 1) squeeze_req = 1'b1;

      relevant = 0;
      while (relevant < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        et   = ETHERTYPE_ARP;
        if (pick < 8) begin
          // Noise: arbitrary EtherType and addresses.
          rnd_a = $urandom;
          et  = rnd_a[ET_W-1:0];
          mac = rand_mac();
          ip  = $urandom;
        end else if (pick < 14) begin
          // ARP from an arbitrary address, nearly always outside the subnet.
          mac = mac_pool[$urandom_range(0, POOL_SIZE - 1)];
          ip  = $urandom;
        end else if (pick < 22) begin
          mac = own_mac_cur;
          ip  = own_ip_cur;
        end else begin
          // Well-formed ARP in the subnet, mostly on this phase's hosts.
          if (pick < 80)
            oct = 8'(win_base + $urandom_range(0, WIN_SPAN - 1));
          else
            oct = 8'($urandom_range(0, 255));
          ip  = {prefix_cur, oct};
          sel = $urandom_range(0, 99);
          mac = (sel < 60) ? mac_pool[$urandom_range(0, POOL_SIZE - 1)] : rand_mac();
        end
        if (et == ETHERTYPE_ARP && ip[IP_W-1:OCT_W] == prefix_cur) relevant++;
        offer_frame(et, mac, ip, next_gap(), ROW_PREDICTED, 1'b0, '0);
      end
      relevant_total += relevant;
      frame_ch.valid <= 1'b0;
      wait_idle();
    end

    if (pending_reports.size() != 0) begin
      $display("ERROR: %0d reports never arrived", pending_reports.size());
      error_count += pending_reports.size();
    end
    $display("Run covered %0d frames (%0d ARP in subnet) over %0d settings, %0d reg writes.",
             frames_in, relevant_total, NUM_PHASES + 1, cfg_writes);
    $display("Reports: %0d new hosts (%0d self), %0d conflicts (%0d on full entries), %0d ok.",
             new_hosts, self_marks, conflicts, full_reports, reports_ok);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/ahct_pkg.sv
src/ahct_if.sv
src/ahct_mem.sv
src/ahct_seq.sv
src/arp_host_conflict_table.sv
src/ahct_checker.sv
tb/sv/arp_host_conflict_table_tb.sv
